// File: hw/rtl/sctf_pkg.sv
// sctf_pkg: shared constants, state encoding and controller/datapath
// command and status structs for the slot cache. No dependencies.
`timescale 1ns / 1ps

package sctf_pkg;

  localparam int ROOM_COUNT = 256;
  localparam int SLOT_COUNT = 64;
  localparam int ROOM_W     = $clog2(ROOM_COUNT);
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int CFG_W      = 7;
  localparam int SCALE_W    = 32;
  localparam int BASE_W     = 8;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int REG_IDX_W  = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_SLOTS_IN_USE = REG_IDX_W'(0);

  localparam logic MODE_TOUCH = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_BASE_RD,
    S_CHECK,
    S_SCAN,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic hit_done;
    logic miss;
    logic scan_step;
    logic alloc;
    logic free_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic scan_found;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/slot_cache_touch_free.sv
// slot_cache_touch_free: top level with the register port, controller and
// datapath. Depends on sctf_pkg, sctf_ctrl and sctf_dp.
`timescale 1ns / 1ps

// Maps room numbers to cache slots. One item at a time: in_stall stays high
// from acceptance until the result is moved into the output register, which
// then holds it while the next item is already being taken. A free runs through
// S_FREE_RD and S_FREE_WR, a touch through S_LOOKUP, S_BASE_RD and S_CHECK; a
// miss adds the free-slot scan, one slot per cycle up to slots_in_use (capped
// at 64), and S_ALLOC. Tables reset through per-entry valid bits, no clearing
// pass. Register slots_in_use sits at byte address 0 of the register port.
module slot_cache_touch_free (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sctf_pkg::APB_AW-1:0]       paddr,
  input  logic [sctf_pkg::APB_DW-1:0]       pwdata,
  output logic [sctf_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [sctf_pkg::ROOM_W-1:0]       room,
  input  logic [sctf_pkg::BASE_W-1:0]       base_room,
  input  logic [sctf_pkg::SCALE_W-1:0]      scale_bits,
  input  logic [sctf_pkg::SLOT_W-1:0]       slot,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sctf_pkg::SLOT_W-1:0]       slot_index,
  output logic                              refill_needed
);

  logic [sctf_pkg::CFG_W-1:0]     slots_in_use;
  logic [sctf_pkg::REG_IDX_W-1:0] reg_idx;
  sctf_pkg::cmd_t                 cmd;
  sctf_pkg::status_t              stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sctf_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= '0;
    end else if (psel && penable && pwrite && pready
                 && reg_idx == sctf_pkg::REG_SLOTS_IN_USE) begin
      slots_in_use <= pwdata[sctf_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (reg_idx == sctf_pkg::REG_SLOTS_IN_USE)
                ? sctf_pkg::APB_DW'(slots_in_use) : '0;

  sctf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  sctf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .room          (room),
    .base_room     (base_room),
    .scale_bits    (scale_bits),
    .slot          (slot),
    .slots_in_use  (slots_in_use),
    .slot_index    (slot_index),
    .refill_needed (refill_needed),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  // an accepted item holds off the next one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous one still in flight");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("output register loaded while occupied");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid without a result load");

endmodule

// File: hw/rtl/sctf_ctrl.sv
// sctf_ctrl: sequencing state machine for touch and free items.
// Depends on sctf_pkg for the state type and command/status structs.
`timescale 1ns / 1ps

module sctf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              mode,
  input  sctf_pkg::status_t stat,
  output sctf_pkg::cmd_t    cmd,
  output logic              in_stall
);

  sctf_pkg::state_t state;
  sctf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sctf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sctf_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (mode == sctf_pkg::MODE_FREE) ? sctf_pkg::S_FREE_RD
                                                     : sctf_pkg::S_LOOKUP;
        end
      end
      sctf_pkg::S_LOOKUP:  state_next = sctf_pkg::S_BASE_RD;
      sctf_pkg::S_BASE_RD: state_next = sctf_pkg::S_CHECK;
      sctf_pkg::S_CHECK: begin
        state_next = stat.hit ? sctf_pkg::S_OUT : sctf_pkg::S_SCAN;
      end
      sctf_pkg::S_SCAN: begin
        if (stat.scan_end || stat.scan_found) begin
          state_next = sctf_pkg::S_ALLOC;
        end
      end
      sctf_pkg::S_ALLOC:   state_next = sctf_pkg::S_OUT;
      sctf_pkg::S_FREE_RD: state_next = sctf_pkg::S_FREE_WR;
      sctf_pkg::S_FREE_WR: state_next = sctf_pkg::S_OUT;
      sctf_pkg::S_OUT: begin
        if (stat.out_free) begin
          state_next = sctf_pkg::S_IDLE;
        end
      end
      default: state_next = sctf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != sctf_pkg::S_IDLE);
    unique case (state)
      sctf_pkg::S_IDLE:    cmd.capture   = in_valid;
      sctf_pkg::S_CHECK: begin
        cmd.hit_done = stat.hit;
        cmd.miss     = !stat.hit;
      end
      sctf_pkg::S_SCAN:    cmd.scan_step = 1'b1;
      sctf_pkg::S_ALLOC:   cmd.alloc     = 1'b1;
      sctf_pkg::S_FREE_WR: cmd.free_wr   = 1'b1;
      sctf_pkg::S_OUT:     cmd.load_out  = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/sctf_dp.sv
// sctf_dp: slot cache datapath with room and slot tables, free scan
// counter and output register. Depends on sctf_pkg for widths and structs.
`timescale 1ns / 1ps

module sctf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  sctf_pkg::cmd_t                cmd,
  output sctf_pkg::status_t             stat,
  input  logic [sctf_pkg::ROOM_W-1:0]   room,
  input  logic [sctf_pkg::BASE_W-1:0]   base_room,
  input  logic [sctf_pkg::SCALE_W-1:0]  scale_bits,
  input  logic [sctf_pkg::SLOT_W-1:0]   slot,
  input  logic [sctf_pkg::CFG_W-1:0]    slots_in_use,
  output logic [sctf_pkg::SLOT_W-1:0]   slot_index,
  output logic                          refill_needed,
  output logic                          out_valid,
  input  logic                          out_stall
);

  // captured item
  logic [sctf_pkg::ROOM_W-1:0]  room_q;
  logic [sctf_pkg::BASE_W-1:0]  base_q;
  logic [sctf_pkg::SCALE_W-1:0] scale_q;
  logic [sctf_pkg::SLOT_W-1:0]  slot_q;

  // room to slot table, valid bit per room
  logic [sctf_pkg::SLOT_W-1:0]  rts_mem [sctf_pkg::ROOM_COUNT];
  logic [sctf_pkg::ROOM_COUNT-1:0] rts_valid;
  logic [sctf_pkg::SLOT_W-1:0]  rts_rd;

  // per-slot tables
  logic [sctf_pkg::ROOM_W-1:0]  sr_mem [sctf_pkg::SLOT_COUNT];
  logic [sctf_pkg::SLOT_COUNT-1:0] sr_valid;
  logic [sctf_pkg::ROOM_W-1:0]  sr_rd;
  logic [sctf_pkg::BASE_W-1:0]  base_mem [sctf_pkg::SLOT_COUNT];
  logic [sctf_pkg::BASE_W-1:0]  base_rd;
  logic [sctf_pkg::SCALE_W-1:0] scale_mem [sctf_pkg::SLOT_COUNT];
  logic [sctf_pkg::SCALE_W-1:0] scale_rd;
  // one bit per slot, set while the slot is free
  logic [sctf_pkg::SLOT_COUNT-1:0] free_vec;

  logic [sctf_pkg::CNT_W-1:0]   cnt;
  logic [sctf_pkg::CNT_W-1:0]   lim;
  logic [sctf_pkg::SLOT_W-1:0]  pick;
  logic [sctf_pkg::SLOT_W-1:0]  res_idx;
  logic                         res_refill;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      room_q  <= room;
      base_q  <= base_room;
      scale_q <= scale_bits;
      slot_q  <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      rts_mem[room_q] <= pick;
    end
    rts_rd <= rts_mem[room_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      sr_mem[pick] <= room_q;
    end
    sr_rd <= sr_mem[slot_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      base_mem[pick] <= base_q;
    end
    base_rd <= base_mem[rts_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      scale_mem[pick] <= scale_q;
    end
    scale_rd <= scale_mem[rts_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rts_valid <= '0;
    end else if (cmd.alloc) begin
      rts_valid[room_q] <= 1'b1;
    end else if (cmd.free_wr && sr_valid[slot_q]) begin
      rts_valid[sr_rd] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sr_valid <= '0;
      free_vec <= '1;
    end else begin
      if (cmd.miss && rts_valid[room_q]) begin
        sr_valid[rts_rd] <= 1'b0;
      end
      if (cmd.alloc) begin
        sr_valid[pick] <= 1'b1;
        free_vec[pick] <= 1'b0;
      end
      if (cmd.free_wr) begin
        sr_valid[slot_q] <= 1'b0;
        free_vec[slot_q] <= 1'b1;
      end
    end
  end

  // search length is capped at the slot count
  assign lim = (slots_in_use > sctf_pkg::CFG_W'(sctf_pkg::SLOT_COUNT))
             ? sctf_pkg::CNT_W'(sctf_pkg::SLOT_COUNT)
             : sctf_pkg::CNT_W'(slots_in_use);

  always_comb begin
    stat.hit        = rts_valid[room_q] && !free_vec[rts_rd]
                    && (base_rd == base_q) && (scale_rd == scale_q);
    stat.scan_end   = (cnt >= lim);
    stat.scan_found = free_vec[cnt[sctf_pkg::SLOT_W-1:0]];
    stat.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.miss) begin
      cnt <= '0;
    end else if (cmd.scan_step && !stat.scan_end && !stat.scan_found) begin
      cnt <= cnt + sctf_pkg::CNT_W'(1);
    end
  end

  // no free slot in range falls back to slot 0
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (stat.scan_end) begin
        pick <= '0;
      end else if (stat.scan_found) begin
        pick <= cnt[sctf_pkg::SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_done) begin
      res_idx    <= rts_rd;
      res_refill <= 1'b0;
    end else if (cmd.alloc) begin
      res_idx    <= pick;
      res_refill <= 1'b1;
    end else if (cmd.free_wr) begin
      res_idx    <= slot_q;
      res_refill <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slot_index    <= res_idx;
      refill_needed <= res_refill;
    end
  end

endmodule
